### src/cra_pkg.sv
// Shared types, constants and status codes for the contiguous transmit ring allocator.
// Used by cra_engine and contiguous_ring_tx_allocator; has no dependencies.
package cra_pkg;

   localparam int BUF_BYTES   = 8192;
   localparam int QUEUE_SLOTS = 64;
   localparam int MIN_FRAME   = 34;

   localparam int BYTE_POS_W = $clog2(BUF_BYTES);
   localparam int BYTE_CNT_W = BYTE_POS_W + 1;
   localparam int SLOT_POS_W = $clog2(QUEUE_SLOTS);
   localparam int SLOT_CNT_W = SLOT_POS_W + 1;
   localparam int LEN_W      = 14;
   localparam int ALEN_W     = LEN_W + 1;
   localparam int STATUS_W   = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_TOO_SMALL   = 3'd1,
      ST_TOO_BIG     = 3'd2,
      ST_NO_SPACE    = 3'd3,
      ST_NO_CONTIG   = 3'd4,
      ST_QUEUE_FULL  = 3'd5,
      ST_NOTHING_OUT = 3'd6
   } status_type;

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_CONSUME = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic [LEN_W-1:0] frame_length;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [BYTE_POS_W-1:0] buffer_offset;
      logic [SLOT_POS_W-1:0] slot_index;
      logic [LEN_W-1:0]      slot_length;
      logic                  wrapped;
      logic [BYTE_CNT_W-1:0] free_bytes;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_POS_W-1:0] addr;
      logic [LEN_W-1:0]      data;
   } memwr_type;

endpackage

### src/cra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the descriptor slot length store.
module cra_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/cra_engine.sv
// Ring pointers and the single-pass allocate / consume decision logic.
// Depends on cra_pkg; the slot length store sits outside in cra_ram.
module cra_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  cra_pkg::req_type              cmd,
   input  logic [cra_pkg::LEN_W-1:0]     head_len,
   output cra_pkg::rsp_type              result,
   output cra_pkg::memwr_type            mem_wr,
   output logic [cra_pkg::SLOT_POS_W-1:0] rd_addr
);

   localparam logic [cra_pkg::BYTE_CNT_W-1:0] BUF_SIZE =
      cra_pkg::BYTE_CNT_W'(cra_pkg::BUF_BYTES);
   localparam logic [cra_pkg::SLOT_CNT_W-1:0] SLOT_FULL =
      cra_pkg::SLOT_CNT_W'(cra_pkg::QUEUE_SLOTS);
   localparam logic [cra_pkg::ALEN_W-1:0] ALIGN_MASK = ~cra_pkg::ALEN_W'(3);

   logic [cra_pkg::BYTE_CNT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [cra_pkg::SLOT_CNT_W-1:0] prod_ff, prod_in, retire_ff, retire_in;

   always_comb begin
      logic [cra_pkg::BYTE_CNT_W-1:0] used_cur, free_cur, used_nxt, free_nxt;
      logic [cra_pkg::BYTE_CNT_W-1:0] tail_room, head_room;
      logic [cra_pkg::BYTE_POS_W-1:0] ph, pt;
      logic [cra_pkg::ALEN_W-1:0]     alen, calen;
      logic [cra_pkg::SLOT_CNT_W-1:0] outstanding;
      logic                           fits_here, fits_start;
      logic [cra_pkg::BYTE_CNT_W-1:0] skip;

      used_cur    = tail_ff - head_ff;
      free_cur    = (used_cur > BUF_SIZE) ? '0 : BUF_SIZE - used_cur;
      ph          = head_ff[cra_pkg::BYTE_POS_W-1:0];
      pt          = tail_ff[cra_pkg::BYTE_POS_W-1:0];
      tail_room   = BUF_SIZE - {1'b0, pt};
      head_room   = BUF_SIZE - {1'b0, ph};
      alen        = ({1'b0, cmd.frame_length} + cra_pkg::ALEN_W'(3)) & ALIGN_MASK;
      calen       = ({1'b0, head_len} + cra_pkg::ALEN_W'(3)) & ALIGN_MASK;
      outstanding = prod_ff - retire_ff;
      fits_here   = (ph > pt) || ({1'b0, tail_room} >= alen);
      fits_start  = ({{(cra_pkg::ALEN_W-cra_pkg::BYTE_POS_W){1'b0}}, ph} >= alen);
      skip        = '0;

      head_in   = head_ff;
      tail_in   = tail_ff;
      prod_in   = prod_ff;
      retire_in = retire_ff;
      mem_wr    = '0;
      result    = '0;
      result.status = cra_pkg::ST_OK;

      if (cmd.mode == cra_pkg::MODE_ALLOC) begin
         if (cmd.frame_length < cra_pkg::LEN_W'(cra_pkg::MIN_FRAME)) begin
            result.status = cra_pkg::ST_TOO_SMALL;
         end else if (cmd.frame_length > cra_pkg::LEN_W'(cra_pkg::BUF_BYTES)) begin
            result.status = cra_pkg::ST_TOO_BIG;
         end else if (alen > {1'b0, free_cur}) begin
            result.status = cra_pkg::ST_NO_SPACE;
         end else if (!fits_here && !fits_start) begin
            result.status = cra_pkg::ST_NO_CONTIG;
         end else if (outstanding == SLOT_FULL) begin
            result.status = cra_pkg::ST_QUEUE_FULL;
         end else begin
            // When the end of the ring is too short, the skipped bytes count as used.
            skip                 = fits_here ? '0 : tail_room;
            tail_in              = tail_ff + skip + alen[cra_pkg::BYTE_CNT_W-1:0];
            prod_in              = prod_ff + 1'b1;
            mem_wr.en            = fire;
            mem_wr.addr          = prod_ff[cra_pkg::SLOT_POS_W-1:0];
            mem_wr.data          = cmd.frame_length;
            result.buffer_offset = fits_here ? pt : '0;
            result.slot_index    = prod_ff[cra_pkg::SLOT_POS_W-1:0];
            result.slot_length   = cmd.frame_length;
            result.wrapped       = !fits_here;
         end
      end else begin
         if (outstanding == '0) begin
            result.status = cra_pkg::ST_NOTHING_OUT;
         end else begin
            if ({1'b0, head_room} >= calen) begin
               result.buffer_offset = ph;
               result.wrapped       = 1'b0;
            end else begin
               skip                 = head_room;
               result.buffer_offset = '0;
               result.wrapped       = 1'b1;
            end
            head_in            = head_ff + skip + calen[cra_pkg::BYTE_CNT_W-1:0];
            retire_in          = retire_ff + 1'b1;
            result.slot_index  = retire_ff[cra_pkg::SLOT_POS_W-1:0];
            result.slot_length = head_len;
         end
      end

      used_nxt          = tail_in - head_in;
      free_nxt          = (used_nxt > BUF_SIZE) ? '0 : BUF_SIZE - used_nxt;
      result.free_bytes = free_nxt;

      if (!fire) begin
         head_in   = head_ff;
         tail_in   = tail_ff;
         prod_in   = prod_ff;
         retire_in = retire_ff;
      end
      rd_addr = retire_in[cra_pkg::SLOT_POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         prod_ff   <= '0;
         retire_ff <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         prod_ff   <= prod_in;
         retire_ff <= retire_in;
      end
   end

endmodule

### src/contiguous_ring_tx_allocator.sv
// Top level of the contiguous transmit ring allocator: input and result registers,
// slot length store and forwarding. Depends on cra_pkg, cra_ram and cra_engine.
//
//   channel   ports                                   direction
//   req       req_valid, req_stall, req_mode,         in (stall out)
//             req_frame_length
//   rsp       rsp_valid, rsp_stall, rsp_status,       out (stall in)
//             rsp_buffer_offset, rsp_slot_index,
//             rsp_slot_length, rsp_wrapped, rsp_free_bytes
//
// One item per cycle is sustained while rsp_stall does not hold the result register.
// Latency is set by the input register and the result register around the decision logic.
// Reset clears the ring pointers and valid flags; the slot length store is not cleared.
// A stalled result holds the item behind it in the input register, and req_stall rises.
module contiguous_ring_tx_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [cra_pkg::LEN_W-1:0]       req_frame_length,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cra_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cra_pkg::BYTE_POS_W-1:0]  rsp_buffer_offset,
   output logic [cra_pkg::SLOT_POS_W-1:0]  rsp_slot_index,
   output logic [cra_pkg::LEN_W-1:0]       rsp_slot_length,
   output logic                            rsp_wrapped,
   output logic [cra_pkg::BYTE_CNT_W-1:0]  rsp_free_bytes
);

   logic                             req_valid_ff;
   cra_pkg::req_type                 req_ff;
   logic                             rsp_valid_ff;
   cra_pkg::rsp_type                 rsp_ff;
   logic                             fire;
   logic                             req_take;
   cra_pkg::rsp_type                 result;
   cra_pkg::memwr_type               mem_wr;
   logic [cra_pkg::SLOT_POS_W-1:0]   rd_addr;
   logic [cra_pkg::LEN_W-1:0]        ram_rd_data;
   logic [cra_pkg::LEN_W-1:0]        head_len;
   logic                             byp_hit_ff;
   logic [cra_pkg::LEN_W-1:0]        byp_data_ff;

   assign fire      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // The store reads old data when a slot is written and read in the same cycle.
   assign head_len = byp_hit_ff ? byp_data_ff : ram_rd_data;

   cra_ram #(
      .WIDTH (cra_pkg::LEN_W),
      .DEPTH (cra_pkg::QUEUE_SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   cra_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .cmd      (req_ff),
      .head_len (head_len),
      .result   (result),
      .mem_wr   (mem_wr),
      .rd_addr  (rd_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= 1'b0;
      end else begin
         byp_hit_ff <= mem_wr.en && (mem_wr.addr == rd_addr);
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (fire) begin
            req_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      byp_data_ff <= mem_wr.data;
      if (req_take) begin
         req_ff.mode         <= cra_pkg::mode_type'(req_mode);
         req_ff.frame_length <= req_frame_length;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_buffer_offset = rsp_ff.buffer_offset;
   assign rsp_slot_index    = rsp_ff.slot_index;
   assign rsp_slot_length   = rsp_ff.slot_length;
   assign rsp_wrapped       = rsp_ff.wrapped;
   assign rsp_free_bytes    = rsp_ff.free_bytes;

endmodule
